[rtl/core/alid_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the positional insert/delete list.
// No dependencies; used by the cells, the controller, the top level and the checker.
package alid_pkg;

   // Default list depth
   localparam int DEF_CAPACITY = 32;

   // Field widths fixed by the interface
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SORTED = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   // Operation broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD      = 3'd0,
      CELL_INSERT    = 3'd1,
      CELL_DELETE    = 3'd2,
      CELL_BUB_START = 3'd3,
      CELL_BUB_STEP  = 3'd4,
      CELL_LOAD_BUS  = 3'd5,
      CELL_SHIFT_BUS = 3'd6
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

[rtl/core/array_list_positional_insert_delete.sv]
`timescale 1ns / 1ps
// Fixed-capacity list of signed 32-bit values with positional insert and delete.
// Request channel (req_): mode, value, 1-based position. Response channel (rsp_):
// status, read value, count after the operation, empty and full flags.
// Every request beat yields exactly one response beat, in order.
// Append, insert at position, remove and every error case register their
// response at the request edge. A read at position p loads the read bus, which
// moves one cell per cycle toward cell 0 until entry p reaches it, then the
// response is registered. A sorted insert places the new value at the tail and
// walks it down the cell row past at most CAPACITY - 1 entries until it settles.
// The next request is taken the cycle after a response is registered, as long
// as the response register is empty or being drained in the same cycle.
// A stalled response holds its payload; no request is taken until it drains.
// Reset (synchronous) empties the list; entry contents are not cleared and are
// never visible, since only entries below the count are ever read.
// Depends on alid_pkg, alid_cell and alid_ctrl.
module array_list_positional_insert_delete #(
   parameter int CAPACITY = alid_pkg::DEF_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [alid_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [alid_pkg::VALUE_W-1:0]   req_value,
   input  logic [alid_pkg::POS_W-1:0]            req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [alid_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [alid_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [alid_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full
);
   import alid_pkg::*;

   localparam int IW = $clog2(CAPACITY);

   cell_cmd_type              cell_cmd;
   logic [IW-1:0]             cell_idx;
   logic signed [VALUE_W-1:0] entry_w [CAPACITY];
   logic signed [VALUE_W-1:0] bus_w   [CAPACITY];
   logic [CAPACITY-1:0]       swap_w;
   logic [CAPACITY-1:0]       stop_w;
   logic                      sort_done;

   // Sequencer and response register
   alid_ctrl #(
      .CAPACITY (CAPACITY),
      .IW       (IW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .cell_cmd       (cell_cmd),
      .cell_idx       (cell_idx),
      .sort_done      (sort_done),
      .bus_head       (bus_w[0])
   );

   // Row of cells, each linked to both neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry, right_entry, right_bus;
      logic                      right_swap;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_left
         assign left_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
         assign right_bus   = '0;
         assign right_swap  = 1'b0;
      end else begin : g_inner_right
         assign right_entry = entry_w[i+1];
         assign right_bus   = bus_w[i+1];
         assign right_swap  = swap_w[i+1];
      end

      alid_cell #(
         .INDEX (i),
         .IW    (IW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .idx         (cell_idx),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_bus   (right_bus),
         .right_swap  (right_swap),
         .entry       (entry_w[i]),
         .bus         (bus_w[i]),
         .swap_out    (swap_w[i]),
         .stop        (stop_w[i])
      );
   end

   // Sorted insert ends once the marked cell stops moving
   assign sort_done = |stop_w;

endmodule

[rtl/core/alid_cell.sv]
`timescale 1ns / 1ps
// One list slot: holds an entry, a sorted-insert marker and a read-bus stage.
// Depends on alid_pkg.
module alid_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  alid_pkg::cell_cmd_type                cmd,
   input  logic [IW-1:0]                         idx,
   input  logic signed [alid_pkg::VALUE_W-1:0]   left_entry,
   input  logic signed [alid_pkg::VALUE_W-1:0]   right_entry,
   input  logic signed [alid_pkg::VALUE_W-1:0]   right_bus,
   input  logic                                  right_swap,
   output logic signed [alid_pkg::VALUE_W-1:0]   entry,
   output logic signed [alid_pkg::VALUE_W-1:0]   bus,
   output logic                                  swap_out,
   output logic                                  stop
);
   import alid_pkg::*;

   localparam logic IS_FIRST = (INDEX == 0);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic signed [VALUE_W-1:0] bus_ff, bus_in;
   logic                      mark_ff, mark_in;
   logic                      at_idx, above_idx, swap_req;

   // Position of this cell relative to the operation index
   assign at_idx    = (idx == IW'(INDEX));
   assign above_idx = (IW'(INDEX) > idx);

   // Marked cell moves the new value down while its left neighbor is not smaller
   assign swap_req = mark_ff && !IS_FIRST && !(left_entry < cmd.value);
   assign swap_out = (cmd.op == CELL_BUB_STEP) && swap_req;
   assign stop     = mark_ff && !swap_req;

   // Next entry, marker and bus values
   always_comb begin
      entry_in = entry_ff;
      bus_in   = bus_ff;
      mark_in  = mark_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (at_idx) begin
               entry_in = cmd.value;
            end else if (above_idx) begin
               entry_in = left_entry;
            end
         end
         CELL_DELETE: begin
            if (at_idx || above_idx) begin
               entry_in = right_entry;
            end
         end
         CELL_BUB_START: begin
            mark_in = at_idx;
            if (at_idx) begin
               entry_in = cmd.value;
            end
         end
         CELL_BUB_STEP: begin
            if (swap_req) begin
               entry_in = left_entry;
               mark_in  = 1'b0;
            end else if (right_swap) begin
               entry_in = cmd.value;
               mark_in  = 1'b1;
            end
         end
         CELL_LOAD_BUS: begin
            bus_in = entry_ff;
         end
         CELL_SHIFT_BUS: begin
            bus_in = right_bus;
         end
         default: begin
         end
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      bus_ff   <= bus_in;
   end

   // Marker
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign entry = entry_ff;
   assign bus   = bus_ff;

endmodule

[rtl/core/alid_ctrl.sv]
`timescale 1ns / 1ps
// Controller: decodes request beats, tracks the element count, drives the
// cell row and registers the response beat. Depends on alid_pkg.
module alid_ctrl #(
   parameter int CAPACITY = alid_pkg::DEF_CAPACITY,
   parameter int IW       = $clog2(CAPACITY)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [alid_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [alid_pkg::VALUE_W-1:0]   req_value,
   input  logic [alid_pkg::POS_W-1:0]            req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [alid_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [alid_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [alid_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   output alid_pkg::cell_cmd_type                cell_cmd,
   output logic [IW-1:0]                         cell_idx,
   input  logic                                  sort_done,
   input  logic signed [alid_pkg::VALUE_W-1:0]   bus_head
);
   import alid_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SORT = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [IW-1:0]             steps_ff, steps_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rd_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_empty_ff, rsp_full_ff;
   logic                      finish, accept, full;
   logic                      ins_bad, idx_bad;
   logic [PW-1:0]             pos_w, cnt_w;
   logic [IW-1:0]             pos_idx, cnt_idx;
   logic [RW-1:0]             cnt_ext;

   // Take a beat when idle and the response register is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Range checks on the requested position
   assign full    = (count_ff == CW'(CAPACITY));
   assign pos_w   = PW'(req_position);
   assign cnt_w   = PW'(count_ff);
   assign ins_bad = (req_position == '0) || (pos_w > cnt_w + PW'(1));
   assign idx_bad = (req_position == '0) || (pos_w > cnt_w);
   assign pos_idx = IW'(req_position - POS_W'(1));
   assign cnt_idx = IW'(count_ff);

   // Operation decode and sequencing
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      value_in       = value_ff;
      steps_in       = steps_ff;
      finish         = 1'b0;
      status_in      = ST_OK;
      rd_in          = '0;
      cell_cmd.op    = CELL_HOLD;
      cell_cmd.value = (state_ff == S_IDLE) ? req_value : value_ff;
      cell_idx       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_APPEND: begin
                     finish = 1'b1;
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_cmd.op = CELL_INSERT;
                        cell_idx    = cnt_idx;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  MODE_INSERT: begin
                     finish = 1'b1;
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (ins_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cell_cmd.op = CELL_INSERT;
                        cell_idx    = pos_idx;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  MODE_SORTED: begin
                     if (full) begin
                        finish    = 1'b1;
                        status_in = ST_FULL;
                     end else begin
                        cell_cmd.op = CELL_BUB_START;
                        cell_idx    = cnt_idx;
                        count_in    = count_ff + CW'(1);
                        value_in    = req_value;
                        state_in    = S_SORT;
                     end
                  end
                  MODE_REMOVE: begin
                     finish = 1'b1;
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (idx_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cell_cmd.op = CELL_DELETE;
                        cell_idx    = pos_idx;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  MODE_READ: begin
                     if (idx_bad) begin
                        finish    = 1'b1;
                        status_in = ST_BADPOS;
                     end else begin
                        cell_cmd.op = CELL_LOAD_BUS;
                        steps_in    = pos_idx;
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                     finish    = 1'b1;
                     status_in = ST_BADPOS;
                  end
               endcase
            end
         end
         S_SORT: begin
            // Marker walks down one cell per cycle until it settles
            cell_cmd.op = CELL_BUB_STEP;
            if (sort_done) begin
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            // Bus shifts toward cell 0 until the wanted entry reaches it
            if (steps_ff == '0) begin
               finish   = 1'b1;
               rd_in    = bus_head;
               state_in = S_IDLE;
            end else begin
               cell_cmd.op = CELL_SHIFT_BUS;
               steps_in    = steps_ff - IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_ext      = RW'(count_in);
   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      steps_ff <= steps_in;
      if (finish) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= rd_in;
         rsp_count_ff  <= cnt_ext[COUNT_W-1:0];
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in == CW'(CAPACITY));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

endmodule

[rtl/core/alid_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the list block, bound to the top level.
// Depends on alid_pkg.
module alid_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [alid_pkg::MODE_W-1:0]           req_mode,
   input logic [alid_pkg::POS_W-1:0]            req_position,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [alid_pkg::STATUS_W-1:0]         rsp_status,
   input logic signed [alid_pkg::VALUE_W-1:0]   rsp_read_value,
   input logic [alid_pkg::COUNT_W-1:0]          rsp_count,
   input logic                                  rsp_is_empty,
   input logic                                  rsp_is_full
);
   import alid_pkg::*;

   // A read at position zero is rejected on the very next beat
   a_read_pos0_badpos: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_READ) && (req_position == '0)
      |=> rsp_valid && (rsp_status == ST_BADPOS))
      else $error("read at position zero not rejected");

   // Failed operations never return data
   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_value == '0))
      else $error("nonzero read value on failed operation");

   // Empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_count == '0) && !rsp_is_full)
      else $error("empty flag inconsistent with count");

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled response changed");

endmodule

bind array_list_positional_insert_delete alid_checker u_alid_checker (.*);
